@@ rtl/assert_macros.svh @@
// Assertion helpers, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/sts_pkg.sv @@
`default_nettype none
package sts_pkg;
   localparam int DEFAULT_MAX_ELEMENTS = 262144;
   localparam int SUM_W = 48;
   localparam int VAL_W = 30;
   localparam int LEN_W = 19;
   localparam int POS_W = 19;
   localparam logic [LEN_W-1:0] RESET_LENGTH = 19'd262144;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_WLEAF, CMD_RD_SIB, CMD_WPAR,
      CMD_L_INIT, CMD_R_INIT, CMD_PARENT, CMD_RD_SIBL, CMD_RD_SIBR,
      CMD_RD_RCHILD, CMD_RD_LCHILD, CMD_FIX_L, CMD_FIX_R, CMD_SET_LEFT,
      CMD_SET_RIGHT, CMD_S_INIT, CMD_RD_L, CMD_RD_R, CMD_ACC, CMD_ACC_SHIFT,
      CMD_SHIFT, CMD_RESP
   } cmd_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECIDE, ST_W_LEAF, ST_W_RD, ST_W_PAR,
      ST_L_INIT, ST_L_UP, ST_L_CHK, ST_L_DN, ST_L_DCHK,
      ST_R_INIT, ST_R_UP, ST_R_CHK, ST_R_DN, ST_R_DCHK,
      ST_S_INIT, ST_S_TEST, ST_S_LACC, ST_S_R, ST_S_RACC, ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_done;
      logic is_query;
      logic in_range;
      logic at_root;
      logic par_root;
      logic node_odd;
      logic node_leaf;
      logic rd_less;
      logic l_lt_r;
      logic l_odd;
      logic r_odd;
   } status_type;
endpackage
`default_nettype wire

@@ rtl/segment_tree_span_sum_top.sv @@
// channel   | ports                                          | handshake
// request   | req_op, req_position, req_operand_value        | start && !busy
// response  | rsp_span_sum                                   | rsp_valid, one cycle
// config    | csr_write_data                                 | csr_write_enable
//
// One item at a time. A write stores the leaf, then does one sibling read and one
// parent write per level up to the root. A query makes two boundary walks up and
// down the min tree, then a sum walk.
// After reset, busy stays high while the tree memories are zeroed.
// Results come out for one cycle; the receiver cannot stall.
`default_nettype none
module segment_tree_span_sum_top #(
   parameter int MAX_ELEMENTS = sts_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_op,
   input  wire logic [sts_pkg::POS_W-1:0]  req_position,
   input  wire logic [sts_pkg::VAL_W-1:0]  req_operand_value,
   output logic                            rsp_valid,
   output logic [sts_pkg::SUM_W-1:0]       rsp_span_sum,
   input  wire logic                       csr_write_enable,
   input  wire logic [sts_pkg::LEN_W-1:0]  csr_write_data
);
   import sts_pkg::*;
`include "assert_macros.svh"

   cmd_type    cmd;
   status_type sts;

   sts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   sts_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_operand_value (req_operand_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_span_sum      (rsp_span_sum)
   );

   `ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
endmodule
`default_nettype wire

@@ rtl/sts_ctrl.sv @@
`default_nettype none
module sts_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire sts_pkg::status_type sts,
   output sts_pkg::cmd_type        cmd,
   output logic                    busy
);
   import sts_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = CMD_NONE;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd = CMD_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.in_range) state_in = sts.is_query ? ST_RESP : ST_IDLE;
            else state_in = sts.is_query ? ST_L_INIT : ST_W_LEAF;
         end
         ST_W_LEAF: begin
            cmd = CMD_WLEAF;
            state_in = ST_W_RD;
         end
         ST_W_RD: begin
            cmd = CMD_RD_SIB;
            state_in = ST_W_PAR;
         end
         ST_W_PAR: begin
            cmd = CMD_WPAR;
            state_in = sts.par_root ? ST_IDLE : ST_W_RD;
         end
         ST_L_INIT: begin
            cmd = CMD_L_INIT;
            state_in = ST_L_UP;
         end
         ST_L_UP: begin
            if (sts.at_root) begin
               state_in = ST_R_INIT;
            end else if (sts.node_odd) begin
               cmd = CMD_RD_SIBL;
               state_in = ST_L_CHK;
            end else begin
               cmd = CMD_PARENT;
            end
         end
         ST_L_CHK: begin
            if (sts.rd_less) begin
               state_in = ST_L_DN;
            end else begin
               cmd = CMD_PARENT;
               state_in = ST_L_UP;
            end
         end
         ST_L_DN: begin
            if (sts.node_leaf) begin
               cmd = CMD_SET_LEFT;
               state_in = ST_R_INIT;
            end else begin
               cmd = CMD_RD_RCHILD;
               state_in = ST_L_DCHK;
            end
         end
         ST_L_DCHK: begin
            if (!sts.rd_less) cmd = CMD_FIX_L;
            state_in = ST_L_DN;
         end
         ST_R_INIT: begin
            cmd = CMD_R_INIT;
            state_in = ST_R_UP;
         end
         ST_R_UP: begin
            if (sts.at_root) begin
               state_in = ST_S_INIT;
            end else if (!sts.node_odd) begin
               cmd = CMD_RD_SIBR;
               state_in = ST_R_CHK;
            end else begin
               cmd = CMD_PARENT;
            end
         end
         ST_R_CHK: begin
            if (sts.rd_less) begin
               state_in = ST_R_DN;
            end else begin
               cmd = CMD_PARENT;
               state_in = ST_R_UP;
            end
         end
         ST_R_DN: begin
            if (sts.node_leaf) begin
               cmd = CMD_SET_RIGHT;
               state_in = ST_S_INIT;
            end else begin
               cmd = CMD_RD_LCHILD;
               state_in = ST_R_DCHK;
            end
         end
         ST_R_DCHK: begin
            if (!sts.rd_less) cmd = CMD_FIX_R;
            state_in = ST_R_DN;
         end
         ST_S_INIT: begin
            cmd = CMD_S_INIT;
            state_in = ST_S_TEST;
         end
         ST_S_TEST: begin
            if (!sts.l_lt_r) begin
               state_in = ST_RESP;
            end else if (sts.l_odd) begin
               cmd = CMD_RD_L;
               state_in = ST_S_LACC;
            end else begin
               state_in = ST_S_R;
            end
         end
         ST_S_LACC: begin
            cmd = CMD_ACC;
            state_in = ST_S_R;
         end
         ST_S_R: begin
            if (sts.r_odd) begin
               cmd = CMD_RD_R;
               state_in = ST_S_RACC;
            end else begin
               cmd = CMD_SHIFT;
               state_in = ST_S_TEST;
            end
         end
         ST_S_RACC: begin
            cmd = CMD_ACC_SHIFT;
            state_in = ST_S_TEST;
         end
         ST_RESP: begin
            cmd = CMD_RESP;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/sts_datapath.sv @@
`default_nettype none
module sts_datapath #(
   parameter int MAX_ELEMENTS = sts_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sts_pkg::cmd_type           cmd,
   output sts_pkg::status_type             sts,
   input  wire logic                       req_op,
   input  wire logic [sts_pkg::POS_W-1:0]  req_position,
   input  wire logic [sts_pkg::VAL_W-1:0]  req_operand_value,
   input  wire logic                       csr_write_enable,
   input  wire logic [sts_pkg::LEN_W-1:0]  csr_write_data,
   output logic                            rsp_valid,
   output logic [sts_pkg::SUM_W-1:0]       rsp_span_sum
);
   import sts_pkg::*;

   localparam int LOGP = $clog2(MAX_ELEMENTS);
   localparam int P = 1 << LOGP;
   localparam int NW = LOGP + 2;
   localparam int AW = LOGP + 1;
   localparam int IW = (LEN_W > LOGP + 1) ? LEN_W : LOGP + 1;

   logic [SUM_W-1:0] sum_mem [2*P];
   logic [VAL_W-1:0] min_mem [2*P];

   logic [LEN_W-1:0] len_ff;
   logic             op_ff, op_in;
   logic [IW-1:0]    pos_ff, pos_in, left_ff, left_in, right_ff, right_in;
   logic [VAL_W-1:0] thr_ff, thr_in, cur_min_ff, cur_min_in, rd_min_ff;
   logic [SUM_W-1:0] acc_ff, acc_in, cur_sum_ff, cur_sum_in, rd_sum_ff;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]    node_ff, node_in, l_ff, l_in, r_ff, r_in;

   logic [IW-1:0]    len_ext, n_act, jpos;
   logic [NW-1:0]    leaf, node_dec, node_inc, node_par, r_dec, jfull;
   logic [NW-1:0]    child_l, child_r, node_sib;
   logic [SUM_W-1:0] par_sum, mem_wsum, rd_data_sum;
   logic [VAL_W-1:0] par_min, mem_wmin;
   logic             mem_we, rd_en;
   logic [AW-1:0]    mem_waddr, rd_addr;

   assign len_ext  = IW'(len_ff);
   assign n_act    = (len_ext == '0) ? IW'(1) :
                     (len_ext > IW'(MAX_ELEMENTS)) ? IW'(MAX_ELEMENTS) : len_ext;
   assign leaf     = NW'(P) + NW'(pos_ff) - NW'(1);
   assign node_dec = node_ff - NW'(1);
   assign node_inc = node_ff + NW'(1);
   assign node_par = node_ff >> 1;
   assign node_sib = node_ff ^ NW'(1);
   assign child_l  = {node_ff[NW-2:0], 1'b0};
   assign child_r  = {node_ff[NW-2:0], 1'b1};
   assign r_dec    = r_ff - NW'(1);
   assign jfull    = node_ff - NW'(P) + NW'(1);
   assign jpos     = IW'(jfull);
   assign par_sum  = cur_sum_ff + rd_sum_ff;
   assign par_min  = (rd_min_ff < cur_min_ff) ? rd_min_ff : cur_min_ff;
   assign rd_data_sum = acc_ff + rd_sum_ff;

   always_comb begin
      op_in = op_ff;
      pos_in = pos_ff;
      thr_in = thr_ff;
      left_in = left_ff;
      right_in = right_ff;
      cur_min_in = cur_min_ff;
      cur_sum_in = cur_sum_ff;
      acc_in = acc_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_valid_in = 1'b0;
      node_in = node_ff;
      l_in = l_ff;
      r_in = r_ff;
      mem_we = 1'b0;
      mem_waddr = node_ff[AW-1:0];
      mem_wsum = '0;
      mem_wmin = '0;
      rd_en = 1'b0;
      rd_addr = node_ff[AW-1:0];
      case (cmd)
         CMD_CLEAR: begin
            mem_we = 1'b1;
            node_in = node_inc;
         end
         CMD_LOAD: begin
            op_in = req_op;
            pos_in = IW'(req_position);
            thr_in = req_operand_value;
            acc_in = '0;
         end
         CMD_WLEAF: begin
            mem_we = 1'b1;
            mem_waddr = leaf[AW-1:0];
            mem_wsum = SUM_W'(thr_ff);
            mem_wmin = thr_ff;
            cur_sum_in = SUM_W'(thr_ff);
            cur_min_in = thr_ff;
            node_in = leaf;
         end
         CMD_RD_SIB: begin
            rd_en = 1'b1;
            rd_addr = node_sib[AW-1:0];
         end
         CMD_WPAR: begin
            mem_we = 1'b1;
            mem_waddr = node_par[AW-1:0];
            mem_wsum = par_sum;
            mem_wmin = par_min;
            cur_sum_in = par_sum;
            cur_min_in = par_min;
            node_in = node_par;
         end
         CMD_L_INIT: begin
            node_in = leaf;
            left_in = IW'(1);
         end
         CMD_R_INIT: begin
            node_in = leaf;
            right_in = n_act;
         end
         CMD_PARENT: node_in = node_par;
         CMD_RD_SIBL: begin
            rd_en = 1'b1;
            rd_addr = node_dec[AW-1:0];
            node_in = node_dec;
         end
         CMD_RD_SIBR: begin
            rd_en = 1'b1;
            rd_addr = node_inc[AW-1:0];
            node_in = node_inc;
         end
         CMD_RD_RCHILD: begin
            rd_en = 1'b1;
            rd_addr = child_r[AW-1:0];
            node_in = child_r;
         end
         CMD_RD_LCHILD: begin
            rd_en = 1'b1;
            rd_addr = child_l[AW-1:0];
            node_in = child_l;
         end
         CMD_FIX_L: node_in = node_dec;
         CMD_FIX_R: node_in = node_inc;
         CMD_SET_LEFT: left_in = jpos + IW'(1);
         CMD_SET_RIGHT: right_in = (jpos > n_act) ? n_act : jpos - IW'(1);
         CMD_S_INIT: begin
            l_in = NW'(P) + NW'(left_ff) - NW'(1);
            r_in = NW'(P) + NW'(right_ff);
         end
         CMD_RD_L: begin
            rd_en = 1'b1;
            rd_addr = l_ff[AW-1:0];
            l_in = l_ff + NW'(1);
         end
         CMD_RD_R: begin
            rd_en = 1'b1;
            rd_addr = r_dec[AW-1:0];
            r_in = r_dec;
         end
         CMD_ACC: acc_in = rd_data_sum;
         CMD_ACC_SHIFT: begin
            acc_in = rd_data_sum;
            l_in = l_ff >> 1;
            r_in = r_ff >> 1;
         end
         CMD_SHIFT: begin
            l_in = l_ff >> 1;
            r_in = r_ff >> 1;
         end
         CMD_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_sum_in = acc_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wsum;
         min_mem[mem_waddr] <= mem_wmin;
      end
      if (rd_en) begin
         rd_sum_ff <= sum_mem[rd_addr];
         rd_min_ff <= min_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= RESET_LENGTH;
         rsp_valid_ff <= 1'b0;
         node_ff <= '0;
      end else begin
         if (csr_write_enable) len_ff <= csr_write_data;
         rsp_valid_ff <= rsp_valid_in;
         node_ff <= node_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      pos_ff <= pos_in;
      thr_ff <= thr_in;
      left_ff <= left_in;
      right_ff <= right_in;
      cur_min_ff <= cur_min_in;
      cur_sum_ff <= cur_sum_in;
      acc_ff <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
      l_ff <= l_in;
      r_ff <= r_in;
   end

   always_comb begin
      sts.clear_done = (node_ff[AW-1:0] == '1);
      sts.is_query   = op_ff;
      sts.in_range   = (pos_ff != '0) && (pos_ff <= n_act);
      sts.at_root    = (node_ff == NW'(1));
      sts.par_root   = (node_par == NW'(1));
      sts.node_odd   = node_ff[0];
      sts.node_leaf  = node_ff[LOGP];
      sts.rd_less    = (rd_min_ff < thr_ff);
      sts.l_lt_r     = (l_ff < r_ff);
      sts.l_odd      = l_ff[0];
      sts.r_odd      = r_ff[0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_span_sum = rsp_sum_ff;
endmodule
`default_nettype wire

@@ tb/segment_tree_span_sum_top_test.sv @@
`default_nettype none
module segment_tree_span_sum_top_test;
   import sts_pkg::*;

   localparam int NODES = 2 * DEFAULT_MAX_ELEMENTS;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_WRITE;
   logic [POS_W-1:0] req_position = '0;
   logic [VAL_W-1:0] req_operand_value = '0;
   logic rsp_valid;
   logic [SUM_W-1:0] rsp_span_sum;
   logic csr_write_enable = 1'b0;
   logic [LEN_W-1:0] csr_write_data = '0;

   segment_tree_span_sum_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_position(req_position),
      .req_operand_value(req_operand_value),
      .rsp_valid(rsp_valid), .rsp_span_sum(rsp_span_sum),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   typedef struct {
      logic             op;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      bit               typed;
      logic [SUM_W-1:0] sum;
   } vector_type;

   bit [SUM_W-1:0] sum_node[NODES];
   bit [VAL_W-1:0] min_node[NODES];
   bit [LEN_W-1:0] length_reg = RESET_LENGTH;
   logic [SUM_W-1:0] span_sums[$];
   int errors = 0;
   int idle_pct = 0;

   initial forever #5 clock = ~clock;

   function automatic int used_length();
      if (length_reg == 0) return 1;
      if (length_reg > DEFAULT_MAX_ELEMENTS) return DEFAULT_MAX_ELEMENTS;
      return int'(length_reg);
   endfunction

   function automatic void tree_store(int pos, bit [VAL_W-1:0] v);
      int n;
      n = DEFAULT_MAX_ELEMENTS + pos - 1;
      sum_node[n] = SUM_W'(v);
      min_node[n] = v;
      n = n >> 1;
      while (n >= 1) begin
         sum_node[n] = sum_node[2*n] + sum_node[2*n+1];
         min_node[n] = (min_node[2*n] < min_node[2*n+1]) ? min_node[2*n] : min_node[2*n+1];
         n = n >> 1;
      end
   endfunction

   function automatic longint tree_min(int lo, int hi);
      int l, r;
      longint m;
      l = DEFAULT_MAX_ELEMENTS + lo - 1;
      r = DEFAULT_MAX_ELEMENTS + hi;
      m = 64'h7fff_ffff_ffff;
      while (l < r) begin
         if (l & 1) begin if (min_node[l] < m) m = longint'(min_node[l]); l++; end
         if (r & 1) begin r--; if (min_node[r] < m) m = longint'(min_node[r]); end
         l = l >> 1;
         r = r >> 1;
      end
      return m;
   endfunction

   function automatic bit [SUM_W-1:0] tree_sum(int lo, int hi);
      int l, r;
      bit [SUM_W-1:0] acc;
      l = DEFAULT_MAX_ELEMENTS + lo - 1;
      r = DEFAULT_MAX_ELEMENTS + hi;
      acc = '0;
      while (l < r) begin
         if (l & 1) begin acc += sum_node[l]; l++; end
         if (r & 1) begin r--; acc += sum_node[r]; end
         l = l >> 1;
         r = r >> 1;
      end
      return acc;
   endfunction

   function automatic bit [SUM_W-1:0] span_sum_of(int pos, longint thr);
      int n, left, right, lo, hi, mid;
      n = used_length();
      if (pos < 1 || pos > n) return '0;
      left = 1;
      right = n;
      if (pos > 1 && tree_min(1, pos - 1) < thr) begin
         lo = 1; hi = pos - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (tree_min(mid, pos - 1) < thr) lo = mid;
            else hi = mid - 1;
         end
         left = lo + 1;
      end
      if (pos < n && tree_min(pos + 1, n) < thr) begin
         lo = pos + 1; hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tree_min(pos + 1, mid) < thr) hi = mid;
            else lo = mid + 1;
         end
         right = lo - 1;
      end
      return tree_sum(left, right);
   endfunction

   task automatic report_mismatch(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
      errors++;
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (span_sums.size() == 0) report_mismatch("unexpected item", rsp_span_sum, '0);
         else if (rsp_span_sum !== span_sums[0]) begin
            report_mismatch("span_sum", rsp_span_sum, span_sums[0]);
            void'(span_sums.pop_front());
         end else void'(span_sums.pop_front());
      end
   end

   task automatic send_item(logic op, int pos, logic [VAL_W-1:0] v, bit typed,
                            logic [SUM_W-1:0] want);
      int gap;
      start <= 1'b1;
      req_op <= op;
      req_position <= pos[POS_W-1:0];
      req_operand_value <= v;
      do @(posedge clock); while (busy);
      if (op == OP_WRITE) begin
         if (pos >= 1 && pos <= used_length()) tree_store(pos, v);
      end else begin
         span_sums.push_back(typed ? want : span_sum_of(pos, longint'(v)));
      end
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         gap = int'($urandom_range(1, 20));
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_length(logic [LEN_W-1:0] len);
      start <= 1'b0;
      @(posedge clock);
      while (span_sums.size() != 0 || busy) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_reg = len;
   endtask

   initial begin
      vector_type vecs[20];
      int lens[10];
      int pcts[4];
      int n, span, base, pos;
      logic op;
      logic [VAL_W-1:0] v;
      vecs = '{
         '{OP_QUERY, 1, 5, 1, 0},
         '{OP_QUERY, 0, 5, 1, 0},
         '{OP_QUERY, 262144, 0, 1, 0},
         '{OP_QUERY, 19'h7ffff, 1, 1, 0},
         '{OP_WRITE, 262144, 1000000000, 0, 0},
         '{OP_QUERY, 262144, 0, 1, 1000000000},
         '{OP_WRITE, 1, 1000000000, 0, 0},
         '{OP_QUERY, 1, 1000000000, 1, 1000000000},
         '{OP_QUERY, 2, 30'h3fffffff, 1, 0},
         '{OP_WRITE, 0, 77, 0, 0},
         '{OP_WRITE, 19'h7ffff, 88, 0, 0},
         '{OP_QUERY, 5, 0, 1, 2000000000},
         '{OP_WRITE, 3, 7, 0, 0},
         '{OP_WRITE, 5, 2, 0, 0},
         '{OP_WRITE, 6, 9, 0, 0},
         '{OP_QUERY, 4, 5, 0, 0},
         '{OP_QUERY, 5, 5, 0, 0},
         '{OP_QUERY, 3, 8, 0, 0},
         '{OP_QUERY, 262143, 1, 0, 0},
         '{OP_QUERY, 2, 0, 0, 0}
      };
      lens = '{0, 1, 2, 17, 64, 19'h7ffff, 300, 262144, 40, 9};
      pcts = '{0, 78, 15, 0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (vecs[i])
         send_item(vecs[i].op, vecs[i].pos, vecs[i].val, vecs[i].typed, vecs[i].sum);
      for (int ph = 0; ph < 10; ph++) begin
         write_length(LEN_W'(lens[ph]));
         idle_pct = pcts[ph % 4];
         n = used_length();
         span = (n < 64) ? n : 64;
         base = (n <= 64) ? 1 :
                ((ph % 2) ? n - span + 1 : int'($urandom_range(1, n - span + 1)));
         for (int k = 0; k < 135; k++) begin
            op = ($urandom_range(99) < 55) ? OP_WRITE : OP_QUERY;
            if ($urandom_range(15) == 0) pos = int'($urandom_range(0, 19'h7ffff));
            else if ($urandom_range(15) == 0) pos = (n + 1) & 19'h7ffff;
            else pos = base + int'($urandom_range(0, span - 1));
            if ($urandom_range(9) == 0) v = VAL_W'($urandom_range(0, 30'h3fffffff));
            else if ($urandom_range(19) == 0) v = 30'd1000000000;
            else v = VAL_W'($urandom_range(0, 20));
            send_item(op, pos, v, 0, 0);
         end
      end
      start <= 1'b0;
      @(posedge clock);
      while (span_sums.size() != 0 || busy) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && span_sums.size() == 0)
         $display("segment_tree_span_sum_top regression: pass");
      else
         $display("segment_tree_span_sum_top regression: fail");
      $finish;
   end

   initial begin
      #40000000;
      $display("segment_tree_span_sum_top regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
